[rtl/wave_grid_stencil_step_assert.svh]
// Assertion macros for the wave grid stencil block.
`ifndef WAVE_GRID_STENCIL_STEP_ASSERT_SVH
`define WAVE_GRID_STENCIL_STEP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define WGS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wgs assertion failed");

// Antecedent implies consequent in the next cycle.
`define WGS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wgs assertion failed");

`endif

[rtl/wgs_pkg.sv]
// Shared types, constants and helpers of the wave grid stencil block.
package wgs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int HEIGHT_W     = 16;
  localparam int SLOPE_W      = 17;
  localparam int SIZE_W       = 7;
  localparam int COEF_FRAC    = 14;

  localparam logic signed [15:0] COEF_PREV_RST   = -16'sd16384;
  localparam logic signed [15:0] COEF_CENTER_RST = 16'sd16384;
  localparam logic signed [15:0] COEF_NEIGH_RST  = 16'sd4096;
  localparam logic [15:0]        TIME_STEP_RST   = 16'd1000;
  localparam logic [6:0]         ROWS_RST        = 7'd64;
  localparam logic [6:0]         COLS_RST        = 7'd64;

  localparam logic [2:0] CFG_COEF_PREV   = 3'd0;
  localparam logic [2:0] CFG_COEF_CENTER = 3'd1;
  localparam logic [2:0] CFG_COEF_NEIGH  = 3'd2;
  localparam logic [2:0] CFG_TIME_STEP   = 3'd3;
  localparam logic [2:0] CFG_ROWS        = 3'd4;
  localparam logic [2:0] CFG_COLS        = 3'd5;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_DIST = 2'd1,
    KIND_READ = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SEL_C, SEL_U, SEL_D, SEL_L, SEL_R
  } cell_sel_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_C, CAP_U, CAP_D, CAP_L, CAP_R
  } cap_sel_t;

  typedef struct packed {
    logic      ld_req;
    logic      acc_add;
    logic      acc_clr;
    logic      bank_flip;
    logic      clr;
    logic      loop_init;
    logic      loop_adv;
    logic      use_loop;
    cell_sel_t sel;
    cap_sel_t  cap;
    logic      mul;
    logic      step_wr;
    logic      dist_wr;
    logic      res_ld;
    logic      res_stepped;
  } wgs_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  dist_ok;
    logic  read_ok;
    logic  step_due;
    logic  grid_empty;
    logic  loop_last;
    logic  clr_last;
  } wgs_status_t;

  function automatic logic signed [15:0] sat_h(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sh7fff;
    else if (v < -36'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[rtl/wave_grid_stencil_step.sv]
// Top level of the 2-D wave grid stencil block.
// Non-stepping tick: S_DECODE, S_TICK, S_DONE; rejected item: S_DECODE, S_DONE.
// Read: S_DECODE, S_RD0-S_RD5, S_DONE; disturb adds S_W0-S_W4 before S_DONE.
// Stepping tick: S_RD0-S_RD5, S_MUL, S_ACC per interior cell, then S_FLIP, with
// every cell read on the single read port of the current height bank.
// One item in flight at a time. Reset: registers take defaults, then a clearing
// pass over all MAX_ROWS*MAX_COLS cells zeroes both banks before any item is taken.
`include "wave_grid_stencil_step_assert.svh"

module wave_grid_stencil_step #(
  parameter int MAX_ROWS = wgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = wgs_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // elapsed[15:0], row[21:16], col[27:22], magnitude[43:28]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // height[15:0], slope_x[32:16], slope_z[49:33]
  output logic [1:0]  m_tuser,   // stepped[0], error[1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  wgs_pkg::wgs_cmd_t    cmd;
  wgs_pkg::wgs_status_t st;

  wgs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .st(st), .cmd(cmd)
  );

  wgs_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cmd(cmd), .st(st)
  );

  `WGS_ASSERT_SAME(a_one_writer, clk, rst, cmd.step_wr, !cmd.dist_wr && !cmd.clr)
  `WGS_ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)
  `WGS_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.res_ld, !m_tvalid || m_tready)
  `WGS_ASSERT_SAME(a_clear_blocks, clk, rst, cmd.clr, !s_tready)

endmodule

[rtl/wgs_ram.sv]
// Generic simple dual-port RAM with registered read.
module wgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/wgs_ctrl.sv]
// Sequencer that steps the datapath through clear, tick, disturb, read and grid step.
module wgs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  wgs_pkg::wgs_status_t st,
  output wgs_pkg::wgs_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DECODE, S_TICK,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_RD5,
    S_MUL, S_ACC, S_FLIP,
    S_W0, S_W1, S_W2, S_W3, S_W4,
    S_DONE
  } state_t;

  state_t state;
  logic   stepped;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    cmd.sel = wgs_pkg::SEL_C;
    cmd.cap = wgs_pkg::CAP_NONE;
    cmd.use_loop = (st.kind == wgs_pkg::KIND_TICK);
    cmd.res_stepped = stepped;
    unique case (state)
      S_CLR:    cmd.clr = 1'b1;
      S_IDLE:   cmd.ld_req = s_tvalid;
      S_DECODE: cmd.acc_add = (st.kind == wgs_pkg::KIND_TICK);
      S_TICK:   cmd.loop_init = st.step_due;
      S_RD0:    cmd.sel = wgs_pkg::SEL_C;
      S_RD1: begin
        cmd.sel = wgs_pkg::SEL_U;
        cmd.cap = wgs_pkg::CAP_C;
      end
      S_RD2: begin
        cmd.sel = wgs_pkg::SEL_D;
        cmd.cap = wgs_pkg::CAP_U;
      end
      S_RD3: begin
        cmd.sel = wgs_pkg::SEL_L;
        cmd.cap = wgs_pkg::CAP_D;
      end
      S_RD4: begin
        cmd.sel = wgs_pkg::SEL_R;
        cmd.cap = wgs_pkg::CAP_L;
      end
      S_RD5:    cmd.cap = wgs_pkg::CAP_R;
      S_MUL:    cmd.mul = 1'b1;
      S_ACC: begin
        cmd.step_wr = 1'b1;
        cmd.loop_adv = !st.loop_last;
      end
      S_FLIP: begin
        cmd.bank_flip = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_W0: begin
        cmd.sel = wgs_pkg::SEL_C;
        cmd.dist_wr = 1'b1;
      end
      S_W1: begin
        cmd.sel = wgs_pkg::SEL_U;
        cmd.dist_wr = 1'b1;
      end
      S_W2: begin
        cmd.sel = wgs_pkg::SEL_D;
        cmd.dist_wr = 1'b1;
      end
      S_W3: begin
        cmd.sel = wgs_pkg::SEL_L;
        cmd.dist_wr = 1'b1;
      end
      S_W4: begin
        cmd.sel = wgs_pkg::SEL_R;
        cmd.dist_wr = 1'b1;
      end
      S_DONE:   cmd.res_ld = out_free;
      default:  cmd.res_ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      stepped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one lands in the same cycle.
      if (m_tvalid && m_tready && !(state == S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: if (st.clr_last) state <= S_IDLE;
        S_IDLE: begin
          if (s_tvalid) begin
            stepped <= 1'b0;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (st.kind)
            wgs_pkg::KIND_TICK: state <= S_TICK;
            wgs_pkg::KIND_DIST: state <= st.dist_ok ? S_RD0 : S_DONE;
            wgs_pkg::KIND_READ: state <= st.read_ok ? S_RD0 : S_DONE;
            default:            state <= S_DONE;
          endcase
        end
        S_TICK: begin
          if (!st.step_due) state <= S_DONE;
          else if (st.grid_empty) state <= S_FLIP;
          else state <= S_RD0;
        end
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_RD3;
        S_RD3: state <= S_RD4;
        S_RD4: state <= S_RD5;
        S_RD5: begin
          unique case (st.kind)
            wgs_pkg::KIND_TICK: state <= S_MUL;
            wgs_pkg::KIND_DIST: state <= S_W0;
            default:            state <= S_DONE;
          endcase
        end
        S_MUL: state <= S_ACC;
        S_ACC: state <= st.loop_last ? S_FLIP : S_RD0;
        S_FLIP: begin
          stepped <= 1'b1;
          state   <= S_DONE;
        end
        S_W0: state <= S_W1;
        S_W1: state <= S_W2;
        S_W2: state <= S_W3;
        S_W3: state <= S_W4;
        S_W4: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/wgs_dp.sv]
// Datapath: configuration, height banks, addressing, stencil arithmetic and result register.
module wgs_dp #(
  parameter int MAX_ROWS = wgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = wgs_pkg::MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [47:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic [55:0]          m_tdata,
  output logic [1:0]           m_tuser,
  input  wgs_pkg::wgs_cmd_t    cmd,
  output wgs_pkg::wgs_status_t st
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW = $clog2(CELLS);
  localparam int SW = wgs_pkg::SIZE_W;
  localparam logic [10:0] MAXR = 11'(MAX_ROWS);
  localparam logic [10:0] MAXC = 11'(MAX_COLS);

  logic signed [15:0] coef_prev, coef_center, coef_neigh;
  logic [15:0]        time_step;
  logic [SW-1:0]      rows_in_use, cols_in_use;

  wgs_pkg::kind_t     kind;
  logic [15:0]        elapsed;
  logic [5:0]         row, col;
  logic signed [15:0] mag;

  logic [31:0]   accum;
  logic          cur_is_b;
  logic [AW-1:0] clr_cnt;
  logic [SW-1:0] li, lj;

  logic signed [15:0] cc, cu, cd, cl, cr, pp;
  logic signed [31:0] prod_p, prod_c;
  logic signed [33:0] prod_n;

  logic signed [15:0]      res_h;
  logic signed [16:0]      res_sx, res_sz;
  logic                    res_st, res_err;

  logic [SW-1:0] nr, nc, ri, ci;
  logic [AW-1:0] x, cur_raddr, cur_waddr;
  logic [32:0]   acc_sum;
  logic signed [17:0] nsum;
  logic signed [35:0] step_acc;
  logic signed [15:0] step_val, dist_val, dist_old, dist_add;
  logic [15:0]   a_rd, b_rd, cur_rd, prev_rd;
  logic          cur_we, prev_we, interior;
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [15:0]   a_wdata, b_wdata;

  // Clamp grid size to the stored extent.
  assign nr = ({4'd0, rows_in_use} > MAXR) ? MAXR[SW-1:0] : rows_in_use;
  assign nc = ({4'd0, cols_in_use} > MAXC) ? MAXC[SW-1:0] : cols_in_use;

  assign ri = cmd.use_loop ? li : {1'b0, row};
  assign ci = cmd.use_loop ? lj : {1'b0, col};
  assign x  = AW'(AW'(ri) * AW'(MAX_COLS) + AW'(ci));

  always_comb begin
    case (cmd.sel)
      wgs_pkg::SEL_U: cur_raddr = x - AW'(MAX_COLS);
      wgs_pkg::SEL_D: cur_raddr = x + AW'(MAX_COLS);
      wgs_pkg::SEL_L: cur_raddr = x - AW'(1);
      wgs_pkg::SEL_R: cur_raddr = x + AW'(1);
      default:        cur_raddr = x;
    endcase
  end
  assign cur_waddr = cur_raddr;

  assign interior = (row != 6'd0) && (col != 6'd0) &&
                    ({1'b0, row} + 7'd1 < nr) && ({1'b0, col} + 7'd1 < nc);

  assign st.kind       = kind;
  assign st.dist_ok    = (row >= 6'd2) && (col >= 6'd2) &&
                         ({1'b0, row} + 7'd3 <= nr) && ({1'b0, col} + 7'd3 <= nc);
  assign st.read_ok    = ({1'b0, row} < nr) && ({1'b0, col} < nc);
  assign st.step_due   = accum >= {16'd0, time_step};
  assign st.grid_empty = (nr < 7'd3) || (nc < 7'd3);
  assign st.loop_last  = (li == nr - 7'd2) && (lj == nc - 7'd2);
  assign st.clr_last   = (clr_cnt == AW'(CELLS - 1));

  assign acc_sum = {1'b0, accum} + {17'd0, elapsed};
  assign nsum = {{2{cu[15]}}, cu} + {{2{cd[15]}}, cd} + {{2{cl[15]}}, cl} + {{2{cr[15]}}, cr};

  // Round half up, then floor shift by the coefficient fraction.
  assign step_acc = {{4{prod_p[31]}}, prod_p} + {{4{prod_c[31]}}, prod_c} +
                    {{2{prod_n[33]}}, prod_n} + 36'sd8192;
  assign step_val = wgs_pkg::sat_h(step_acc >>> wgs_pkg::COEF_FRAC);

  always_comb begin
    case (cmd.sel)
      wgs_pkg::SEL_U: dist_old = cu;
      wgs_pkg::SEL_D: dist_old = cd;
      wgs_pkg::SEL_L: dist_old = cl;
      wgs_pkg::SEL_R: dist_old = cr;
      default:        dist_old = cc;
    endcase
  end
  assign dist_add = (cmd.sel == wgs_pkg::SEL_C) ? mag : (mag >>> 1);
  assign dist_val = wgs_pkg::sat_h({{20{dist_old[15]}}, dist_old} +
                                   {{20{dist_add[15]}}, dist_add});

  assign cur_we  = cmd.dist_wr;
  assign prev_we = cmd.step_wr;
  assign cur_rd  = cur_is_b ? b_rd : a_rd;
  assign prev_rd = cur_is_b ? a_rd : b_rd;

  always_comb begin
    if (cmd.clr) begin
      a_we = 1'b1;
      b_we = 1'b1;
      a_waddr = clr_cnt;
      b_waddr = clr_cnt;
      a_wdata = '0;
      b_wdata = '0;
    end else begin
      a_we    = cur_is_b ? prev_we : cur_we;
      b_we    = cur_is_b ? cur_we : prev_we;
      a_waddr = cur_is_b ? x : cur_waddr;
      b_waddr = cur_is_b ? cur_waddr : x;
      a_wdata = cur_is_b ? step_val : dist_val;
      b_wdata = cur_is_b ? dist_val : step_val;
    end
    a_raddr = cur_is_b ? x : cur_raddr;
    b_raddr = cur_is_b ? cur_raddr : x;
  end

  wgs_ram #(.WIDTH(wgs_pkg::HEIGHT_W), .DEPTH(CELLS)) u_bank_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rd)
  );

  wgs_ram #(.WIDTH(wgs_pkg::HEIGHT_W), .DEPTH(CELLS)) u_bank_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_prev   <= wgs_pkg::COEF_PREV_RST;
      coef_center <= wgs_pkg::COEF_CENTER_RST;
      coef_neigh  <= wgs_pkg::COEF_NEIGH_RST;
      time_step   <= wgs_pkg::TIME_STEP_RST;
      rows_in_use <= wgs_pkg::ROWS_RST;
      cols_in_use <= wgs_pkg::COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wgs_pkg::CFG_COEF_PREV:   coef_prev   <= cfg_data;
        wgs_pkg::CFG_COEF_CENTER: coef_center <= cfg_data;
        wgs_pkg::CFG_COEF_NEIGH:  coef_neigh  <= cfg_data;
        wgs_pkg::CFG_TIME_STEP:   time_step   <= cfg_data;
        wgs_pkg::CFG_ROWS:        rows_in_use <= cfg_data[SW-1:0];
        wgs_pkg::CFG_COLS:        cols_in_use <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      cur_is_b <= 1'b0;
      clr_cnt  <= '0;
      li       <= '0;
      lj       <= '0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.acc_add) accum <= acc_sum[32] ? 32'hffff_ffff : acc_sum[31:0];
      if (cmd.acc_clr) accum <= '0;
      if (cmd.bank_flip) cur_is_b <= !cur_is_b;
      if (cmd.loop_init) begin
        li <= SW'(1);
        lj <= SW'(1);
      end else if (cmd.loop_adv) begin
        if (lj == nc - 7'd2) begin
          lj <= SW'(1);
          li <= li + SW'(1);
        end else begin
          lj <= lj + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      kind    <= wgs_pkg::kind_t'(s_tuser);
      elapsed <= s_tdata[15:0];
      row     <= s_tdata[21:16];
      col     <= s_tdata[27:22];
      mag     <= s_tdata[43:28];
    end
    case (cmd.cap)
      wgs_pkg::CAP_C: begin
        cc <= cur_rd;
        pp <= prev_rd;
      end
      wgs_pkg::CAP_U: cu <= cur_rd;
      wgs_pkg::CAP_D: cd <= cur_rd;
      wgs_pkg::CAP_L: cl <= cur_rd;
      wgs_pkg::CAP_R: cr <= cur_rd;
      default: ;
    endcase
    if (cmd.mul) begin
      prod_p <= pp * coef_prev;
      prod_c <= cc * coef_center;
      prod_n <= nsum * coef_neigh;
    end
    if (cmd.res_ld) begin
      res_st  <= cmd.res_stepped;
      res_err <= ((kind == wgs_pkg::KIND_DIST) && !st.dist_ok) ||
                 ((kind == wgs_pkg::KIND_READ) && !st.read_ok) ||
                 (kind == wgs_pkg::KIND_BAD);
      if ((kind == wgs_pkg::KIND_READ) && st.read_ok) begin
        res_h  <= cc;
        res_sx <= interior ? ({cl[15], cl} - {cr[15], cr}) : '0;
        res_sz <= interior ? ({cd[15], cd} - {cu[15], cu}) : '0;
      end else begin
        res_h  <= '0;
        res_sx <= '0;
        res_sz <= '0;
      end
    end
  end

  assign m_tdata = {6'd0, res_sz, res_sx, res_h};
  assign m_tuser = {res_err, res_st};

endmodule
